@@ rtl/core/rbpe_pkg.sv @@
`default_nettype none

package rbpe_pkg;

   // default sizes of the stores and the curve order
   localparam int MAX_POINTS_DEF  = 64;
   localparam int MAX_KNOTS_DEF   = 128;
   localparam int CURVE_ORDER_DEF = 4;

   // request codes
   localparam logic [1:0] REQ_WRITE_POINT = 2'd0;
   localparam logic [1:0] REQ_WRITE_KNOT  = 2'd1;
   localparam logic [1:0] REQ_EVAL        = 2'd2;

   // register indexes on the csr port
   localparam logic CSR_POINT_COUNT = 1'b0;
   localparam logic CSR_KNOT_COUNT  = 1'b1;

   // register reset values
   localparam logic [6:0] POINT_COUNT_RST = 7'd4;
   localparam logic [7:0] KNOT_COUNT_RST  = 8'd8;

   // time limits, Q1.16
   localparam logic [16:0] TIME_ONE = 17'd65536;
   localparam logic [16:0] TIME_MIN = 17'd1;

   // serial divider widths
   localparam int DIV_DD_W  = 80;
   localparam int DIV_DV_W  = 64;
   localparam int DIV_CNT_W = $clog2(DIV_DD_W);

   // shared multiplier operand width
   localparam int MUL_W = 34;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

@@ rtl/core/rbpe_divider.sv @@
`default_nettype none

module rbpe_divider (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   input  wire [rbpe_pkg::DIV_DD_W-1:0]     dividend,
   input  wire [rbpe_pkg::DIV_DV_W-1:0]     divisor,
   output logic [rbpe_pkg::DIV_DD_W-1:0]    quotient,
   output rbpe_pkg::div_status_type         status
);

   localparam int DD = rbpe_pkg::DIV_DD_W;
   localparam int DV = rbpe_pkg::DIV_DV_W;

   logic [DV:0]                       rem_ff;
   logic [DD-1:0]                     quo_ff;
   logic [DV-1:0]                     dv_ff;
   logic [rbpe_pkg::DIV_CNT_W-1:0]    cnt_ff;
   logic                              busy_ff;
   logic                              done_ff;

   logic [DV:0] rem_sh;
   logic [DV:0] rem_diff;
   logic        ge;

   // one restoring step per cycle
   assign rem_sh   = {rem_ff[DV-1:0], quo_ff[DD-1]};
   assign ge       = (rem_sh >= {1'b0, dv_ff});
   assign rem_diff = rem_sh - {1'b0, dv_ff};

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == rbpe_pkg::DIV_CNT_W'(DD - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath, quotient bits shift in as dividend bits shift out
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dv_ff  <= divisor;
      end else if (busy_ff) begin
         rem_ff <= ge ? rem_diff : rem_sh;
         quo_ff <= {quo_ff[DD-2:0], ge};
      end
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire

@@ rtl/core/rational_bspline_point_eval_unit.sv @@
`default_nettype none

// Rational B-spline point evaluator. Control points and knots are written with
// commands (req_type 0 and 1); an evaluate command (req_type 2) returns one result beat
// on rsp_valid, which the receiver must take in that cycle since it cannot stall. Each
// control point in use at order 4 runs the Cox-de Boor triangle, which needs up to twelve
// basis ratios, each through the shared bit-serial divider, with the knots fetched one
// per cycle from the knot memory. The three final quotients also use the divider; a zero
// total weight skips them.
module rational_bspline_point_eval_unit #(
   parameter int MAX_POINTS  = rbpe_pkg::MAX_POINTS_DEF,
   parameter int MAX_KNOTS   = rbpe_pkg::MAX_KNOTS_DEF,
   parameter int CURVE_ORDER = rbpe_pkg::CURVE_ORDER_DEF
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   output logic        busy,
   input  wire  [1:0]  req_type,
   input  wire  [6:0]  req_entry_index,
   input  wire  [31:0] req_point_x,
   input  wire  [31:0] req_point_y,
   input  wire  [31:0] req_point_z,
   input  wire  [31:0] req_point_weight,
   input  wire  [31:0] req_knot_value,
   input  wire  [16:0] req_eval_time,
   output logic        rsp_valid,
   output logic [31:0] rsp_pos_x,
   output logic [31:0] rsp_pos_y,
   output logic [31:0] rsp_pos_z,
   output logic        rsp_weight_zero,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire         csr_index,
   input  wire  [7:0]  csr_wdata
);

   localparam int PAW = $clog2(MAX_POINTS);
   localparam int KAW = $clog2(MAX_KNOTS);
   localparam int PCW = $clog2(MAX_POINTS + 1);
   localparam int KNW = $clog2(MAX_KNOTS + 1);
   localparam int KIW = $clog2(MAX_POINTS + MAX_KNOTS + CURVE_ORDER + 1);
   localparam int OW  = $clog2(CURVE_ORDER + 1);
   localparam int NB1 = (CURVE_ORDER > 1) ? 1 : 0;
   localparam int DD  = rbpe_pkg::DIV_DD_W;
   localparam int DV  = rbpe_pkg::DIV_DV_W;
   localparam int MW  = rbpe_pkg::MUL_W;

   // sequencer states
   localparam logic [4:0] ST_IDLE     = 5'd0;
   localparam logic [4:0] ST_LAST_RD  = 5'd1;
   localparam logic [4:0] ST_LAST_WT  = 5'd2;
   localparam logic [4:0] ST_T_SET    = 5'd3;
   localparam logic [4:0] ST_PT_START = 5'd4;
   localparam logic [4:0] ST_NODE     = 5'd5;
   localparam logic [4:0] ST_RD0      = 5'd6;
   localparam logic [4:0] ST_RD1      = 5'd7;
   localparam logic [4:0] ST_RD2      = 5'd8;
   localparam logic [4:0] ST_RD3      = 5'd9;
   localparam logic [4:0] ST_RD4      = 5'd10;
   localparam logic [4:0] ST_TERM     = 5'd11;
   localparam logic [4:0] ST_DIV      = 5'd12;
   localparam logic [4:0] ST_MUL      = 5'd13;
   localparam logic [4:0] ST_ACC      = 5'd14;
   localparam logic [4:0] ST_INS      = 5'd15;
   localparam logic [4:0] ST_NW_MUL   = 5'd16;
   localparam logic [4:0] ST_NW_SET   = 5'd17;
   localparam logic [4:0] ST_C_MUL    = 5'd18;
   localparam logic [4:0] ST_C_ACC    = 5'd19;
   localparam logic [4:0] ST_FIN      = 5'd20;
   localparam logic [4:0] ST_FDIV     = 5'd21;
   localparam logic [4:0] ST_FWAIT    = 5'd22;

   localparam logic signed [32:0] Q30_ONE  = 33'sh0_4000_0000;
   localparam logic signed [35:0] BLIM_HI  = 36'sh0_8000_0000;
   localparam logic signed [35:0] BLIM_LO  = -36'sh0_8000_0000;
   localparam logic signed [35:0] I32_HI   = 36'sh0_7FFF_FFFF;
   localparam logic signed [35:0] I32_LO   = -36'sh0_8000_0000;

   logic [4:0]              state_ff, state_in;
   logic [6:0]              point_count_ff;
   logic [7:0]              knot_count_ff;
   logic [16:0]             tm_ff, tm_in;
   logic [31:0]             t_ff, t_in;
   logic [PCW-1:0]          pt_ff, pt_in;
   logic [OW-1:0]           k_ff, k_in;
   logic [OW-1:0]           s_ff, s_in;
   logic                    side_ff, side_in;
   logic [1:0]              cc_ff, cc_in;
   logic [31:0]             ka_ff, ka_in, kb_ff, kb_in, kc_ff, kc_in, kd_ff, kd_in;
   logic signed [32:0]      nb_ff [CURVE_ORDER];
   logic signed [32:0]      nb_in [CURVE_ORDER];
   logic signed [35:0]      bacc_ff, bacc_in;
   logic signed [32:0]      ratio_ff, ratio_in;
   logic                    div_neg_ff, div_neg_in;
   logic signed [2*MW-1:0]  prod_ff;
   logic signed [31:0]      nw_ff, nw_in;
   logic signed [63:0]      acc_w_ff, acc_w_in;
   logic signed [63:0]      acc_ff [3];
   logic signed [63:0]      acc_in [3];
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [31:0]             pos_ff [3];
   logic [31:0]             pos_in [3];
   logic                    wz_ff, wz_in;

   logic [127:0]            point_mem [MAX_POINTS];
   logic [31:0]             knot_mem [MAX_KNOTS];
   logic [127:0]            point_q_ff;
   logic [31:0]             knot_q_ff;

   logic                    accept;
   logic                    pt_wr, kn_wr;
   logic [KNW-1:0]          kn_use;
   logic [PCW-1:0]          pc_use;
   logic [OW:0]             koff;
   logic [KIW-1:0]          kidx;
   logic [KIW-1:0]          kidx_cl;
   logic [KAW-1:0]          knot_addr;

   logic signed [MW-1:0]    mul_a, mul_b;
   logic                    div_start;
   logic [DD-1:0]           div_dividend;
   logic [DV-1:0]           div_divisor;
   logic [DD-1:0]           div_quotient;
   rbpe_pkg::div_status_type div_status;

   logic                    shift_en;
   logic                    step_adv;
   logic signed [32:0]      ins_val;
   logic signed [32:0]      ind_val;
   logic signed [32:0]      bsat;
   logic signed [31:0]      nwsat;
   logic signed [32:0]      rsat;
   logic [31:0]             fsat;
   logic                    q_big;
   logic signed [32:0]      t_num, t_den;
   logic [32:0]             t_num_mag, t_den_mag;
   logic [63:0]             f_num_mag, f_den_mag;
   logic signed [35:0]      bterm;
   logic signed [35:0]      nwraw;
   logic signed [31:0]      crd;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign pt_wr = accept && (req_type == rbpe_pkg::REQ_WRITE_POINT)
                  && (32'(req_entry_index) < MAX_POINTS);
   assign kn_wr = accept && (req_type == rbpe_pkg::REQ_WRITE_KNOT)
                  && (32'(req_entry_index) < MAX_KNOTS);

   // counts in use
   always_comb begin
      if (knot_count_ff == 8'd0) begin
         kn_use = KNW'(1);
      end else if (32'(knot_count_ff) > MAX_KNOTS) begin
         kn_use = KNW'(MAX_KNOTS);
      end else begin
         kn_use = KNW'(knot_count_ff);
      end
      if (32'(point_count_ff) > MAX_POINTS) begin
         pc_use = PCW'(MAX_POINTS);
      end else begin
         pc_use = PCW'(point_count_ff);
      end
   end

   // knot address, clamped to the last knot in use
   always_comb begin
      case (state_ff)
         ST_RD0:  koff = {1'b0, s_ff};
         ST_RD1:  koff = {1'b0, s_ff} + {1'b0, k_ff} - 1'b1;
         ST_RD2:  koff = {1'b0, s_ff} + 1'b1;
         ST_RD3:  koff = {1'b0, s_ff} + {1'b0, k_ff};
         default: koff = '0;
      endcase
      kidx = KIW'(pt_ff) + KIW'(koff);
      if (state_ff == ST_LAST_RD || kidx >= KIW'(kn_use)) begin
         kidx_cl = KIW'(kn_use) - 1'b1;
      end else begin
         kidx_cl = kidx;
      end
      knot_addr = kidx_cl[KAW-1:0];
   end

   // point store, x y z w packed low to high
   always_ff @(posedge clock) begin
      if (pt_wr) begin
         point_mem[PAW'(req_entry_index)] <=
            {req_point_weight, req_point_z, req_point_y, req_point_x};
      end
      point_q_ff <= point_mem[pt_ff[PAW-1:0]];
   end

   // knot store
   always_ff @(posedge clock) begin
      if (kn_wr) begin
         knot_mem[KAW'(req_entry_index)] <= req_knot_value;
      end
      knot_q_ff <= knot_mem[knot_addr];
   end

   // shared serial divider
   rbpe_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .status   (div_status)
   );

   // operand selection and saturation
   always_comb begin
      ind_val = (t_ff >= ka_ff && t_ff <= kc_ff) ? Q30_ONE : 33'sd0;
      if (bacc_ff > BLIM_HI) begin
         bsat = BLIM_HI[32:0];
      end else if (bacc_ff < BLIM_LO) begin
         bsat = BLIM_LO[32:0];
      end else begin
         bsat = bacc_ff[32:0];
      end
      bterm = $signed(prod_ff[65:30]);
      nwraw = $signed(prod_ff[65:30]);
      if (nwraw > I32_HI) begin
         nwsat = I32_HI[31:0];
      end else if (nwraw < I32_LO) begin
         nwsat = I32_LO[31:0];
      end else begin
         nwsat = nwraw[31:0];
      end
      q_big = |div_quotient[DD-1:31];
      if (q_big) begin
         rsat = div_neg_ff ? -$signed(33'h0_8000_0000) : $signed(33'h0_8000_0000);
         fsat = div_neg_ff ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         rsat = div_neg_ff ? -$signed({2'b00, div_quotient[30:0]})
                           : $signed({2'b00, div_quotient[30:0]});
         fsat = div_neg_ff ? (32'd0 - div_quotient[31:0]) : div_quotient[31:0];
      end
      if (side_ff) begin
         t_num = $signed({1'b0, kd_ff}) - $signed({1'b0, t_ff});
         t_den = $signed({1'b0, kd_ff}) - $signed({1'b0, kc_ff});
      end else begin
         t_num = $signed({1'b0, t_ff}) - $signed({1'b0, ka_ff});
         t_den = $signed({1'b0, kb_ff}) - $signed({1'b0, ka_ff});
      end
      t_num_mag = t_num[32] ? 33'(-t_num) : 33'(t_num);
      t_den_mag = t_den[32] ? 33'(-t_den) : 33'(t_den);
      f_num_mag = acc_ff[cc_ff][63] ? (64'd0 - acc_ff[cc_ff]) : acc_ff[cc_ff];
      f_den_mag = acc_w_ff[63] ? (64'd0 - acc_w_ff) : acc_w_ff;
      case (cc_ff)
         2'd0:    crd = $signed(point_q_ff[31:0]);
         2'd1:    crd = $signed(point_q_ff[63:32]);
         default: crd = $signed(point_q_ff[95:64]);
      endcase
   end

   // multiplier operands
   always_comb begin
      case (state_ff)
         ST_LAST_WT: begin
            mul_a = $signed({17'd0, tm_ff});
            mul_b = $signed({2'b00, knot_q_ff});
         end
         ST_MUL: begin
            mul_a = MW'(ratio_ff);
            mul_b = side_ff ? MW'(nb_ff[NB1]) : MW'(nb_ff[0]);
         end
         ST_NW_MUL: begin
            mul_a = MW'(nb_ff[0]);
            mul_b = MW'($signed(point_q_ff[127:96]));
         end
         ST_C_MUL: begin
            mul_a = MW'(nw_ff);
            mul_b = MW'(crd);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      tm_in        = tm_ff;
      t_in         = t_ff;
      pt_in        = pt_ff;
      k_in         = k_ff;
      s_in         = s_ff;
      side_in      = side_ff;
      cc_in        = cc_ff;
      ka_in        = ka_ff;
      kb_in        = kb_ff;
      kc_in        = kc_ff;
      kd_in        = kd_ff;
      nb_in        = nb_ff;
      bacc_in      = bacc_ff;
      ratio_in     = ratio_ff;
      div_neg_in   = div_neg_ff;
      nw_in        = nw_ff;
      acc_w_in     = acc_w_ff;
      acc_in       = acc_ff;
      pos_in       = pos_ff;
      wz_in        = wz_ff;
      rsp_valid_in = 1'b0;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      shift_en     = 1'b0;
      step_adv     = 1'b0;
      ins_val      = nb_ff[0];

      case (state_ff)
         ST_IDLE: begin
            if (accept && req_type == rbpe_pkg::REQ_EVAL) begin
               if (req_eval_time < rbpe_pkg::TIME_MIN) begin
                  tm_in = rbpe_pkg::TIME_MIN;
               end else if (req_eval_time > rbpe_pkg::TIME_ONE) begin
                  tm_in = rbpe_pkg::TIME_ONE;
               end else begin
                  tm_in = req_eval_time;
               end
               acc_w_in  = '0;
               acc_in[0] = '0;
               acc_in[1] = '0;
               acc_in[2] = '0;
               pt_in     = '0;
               state_in  = ST_LAST_RD;
            end
         end
         ST_LAST_RD: state_in = ST_LAST_WT;
         ST_LAST_WT: state_in = ST_T_SET;
         ST_T_SET: begin
            t_in     = prod_ff[47:16];
            state_in = (pc_use == '0) ? ST_FIN : ST_PT_START;
         end
         ST_PT_START: begin
            k_in     = OW'(1);
            s_in     = '0;
            state_in = ST_NODE;
         end
         ST_NODE: begin
            if (32'(s_ff) < CURVE_ORDER - 32'(k_ff) + 1) begin
               bacc_in  = '0;
               side_in  = 1'b0;
               state_in = ST_RD0;
            end else begin
               // rotate an unused slot past the front
               shift_en = 1'b1;
               ins_val  = nb_ff[0];
               step_adv = 1'b1;
            end
         end
         ST_RD0: state_in = ST_RD1;
         ST_RD1: begin
            ka_in    = knot_q_ff;
            state_in = ST_RD2;
         end
         ST_RD2: begin
            kb_in    = knot_q_ff;
            state_in = ST_RD3;
         end
         ST_RD3: begin
            kc_in    = knot_q_ff;
            state_in = ST_RD4;
         end
         ST_RD4: begin
            kd_in    = knot_q_ff;
            state_in = (k_ff == OW'(1)) ? ST_INS : ST_TERM;
         end
         ST_TERM: begin
            if (t_den == 33'sd0) begin
               // zero knot span, term dropped
               if (!side_ff) begin
                  side_in = 1'b1;
               end else begin
                  state_in = ST_INS;
               end
            end else begin
               div_start    = 1'b1;
               div_dividend = DD'({t_num_mag, 30'd0});
               div_divisor  = DV'(t_den_mag);
               div_neg_in   = t_num[32] ^ t_den[32];
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               ratio_in = rsat;
               state_in = ST_MUL;
            end
         end
         ST_MUL: state_in = ST_ACC;
         ST_ACC: begin
            bacc_in = bacc_ff + bterm;
            if (!side_ff) begin
               side_in  = 1'b1;
               state_in = ST_TERM;
            end else begin
               state_in = ST_INS;
            end
         end
         ST_INS: begin
            shift_en = 1'b1;
            ins_val  = (k_ff == OW'(1)) ? ind_val : bsat;
            step_adv = 1'b1;
         end
         ST_NW_MUL: state_in = ST_NW_SET;
         ST_NW_SET: begin
            nw_in    = nwsat;
            acc_w_in = acc_w_ff + 64'(nwsat);
            cc_in    = 2'd0;
            state_in = ST_C_MUL;
         end
         ST_C_MUL: state_in = ST_C_ACC;
         ST_C_ACC: begin
            acc_in[cc_ff] = acc_ff[cc_ff] + 64'($signed(prod_ff[67:16]));
            if (cc_ff == 2'd2) begin
               pt_in    = pt_ff + 1'b1;
               state_in = (pt_ff + 1'b1 == pc_use) ? ST_FIN : ST_PT_START;
            end else begin
               cc_in    = cc_ff + 1'b1;
               state_in = ST_C_MUL;
            end
         end
         ST_FIN: begin
            if (acc_w_ff == 64'sd0) begin
               pos_in[0]    = '0;
               pos_in[1]    = '0;
               pos_in[2]    = '0;
               wz_in        = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               cc_in    = 2'd0;
               state_in = ST_FDIV;
            end
         end
         ST_FDIV: begin
            div_start    = 1'b1;
            div_dividend = DD'({f_num_mag, 16'd0});
            div_divisor  = DV'(f_den_mag);
            div_neg_in   = acc_ff[cc_ff][63] ^ acc_w_ff[63];
            state_in     = ST_FWAIT;
         end
         ST_FWAIT: begin
            if (div_status.done) begin
               pos_in[cc_ff] = fsat;
               if (cc_ff == 2'd2) begin
                  wz_in        = 1'b0;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  cc_in    = cc_ff + 1'b1;
                  state_in = ST_FDIV;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // basis triangle kept as a rotating line, new value enters at the back
      if (shift_en) begin
         for (int j = 0; j < CURVE_ORDER - 1; j++) begin
            nb_in[j] = nb_ff[j + 1];
         end
         nb_in[CURVE_ORDER - 1] = ins_val;
      end

      // step and level counters
      if (step_adv) begin
         if (s_ff == OW'(CURVE_ORDER - 1)) begin
            s_in = '0;
            if (k_ff == OW'(CURVE_ORDER)) begin
               state_in = ST_NW_MUL;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = ST_NODE;
            end
         end else begin
            s_in     = s_ff + 1'b1;
            state_in = ST_NODE;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         point_count_ff <= rbpe_pkg::POINT_COUNT_RST;
         knot_count_ff  <= rbpe_pkg::KNOT_COUNT_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               rbpe_pkg::CSR_POINT_COUNT: point_count_ff <= csr_wdata[6:0];
               rbpe_pkg::CSR_KNOT_COUNT:  knot_count_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      tm_ff      <= tm_in;
      t_ff       <= t_in;
      pt_ff      <= pt_in;
      k_ff       <= k_in;
      s_ff       <= s_in;
      side_ff    <= side_in;
      cc_ff      <= cc_in;
      ka_ff      <= ka_in;
      kb_ff      <= kb_in;
      kc_ff      <= kc_in;
      kd_ff      <= kd_in;
      nb_ff      <= nb_in;
      bacc_ff    <= bacc_in;
      ratio_ff   <= ratio_in;
      div_neg_ff <= div_neg_in;
      prod_ff    <= mul_a * mul_b;
      nw_ff      <= nw_in;
      acc_w_ff   <= acc_w_in;
      acc_ff     <= acc_in;
      pos_ff     <= pos_in;
      wz_ff      <= wz_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pos_x       = pos_ff[0];
   assign rsp_pos_y       = pos_ff[1];
   assign rsp_pos_z       = pos_ff[2];
   assign rsp_weight_zero = wz_ff;

   // a result beat lasts one cycle
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result beat longer than one cycle");

   // a write command never produces a result
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && req_type != rbpe_pkg::REQ_EVAL) |=> !rsp_valid)
      else $error("result after a write command");

   // leaving an evaluation always delivers its result
   a_busy_end: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> rsp_valid)
      else $error("evaluation ended without a result");

   // the divider is only started when free
   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("divider started while busy");

endmodule

`default_nettype wire
